FILE: hdl/sdbrr_pkg.sv
// ----------------------------------------------------------------------------
// sdbrr_pkg
// Types, sizes and helper functions shared by the dead-block RRIP engine.
// ----------------------------------------------------------------------------
package sdbrr_pkg;

   localparam int NUM_SETS     = 2048;
   localparam int NUM_WAYS     = 16;
   localparam int SIG_WIDTH    = 6;
   localparam int PSEL_WIDTH   = 10;
   localparam int LEADER_SETS  = 32;

   localparam int SET_W        = $clog2(NUM_SETS);
   localparam int WAY_W        = $clog2(NUM_WAYS);
   localparam int BLK_W        = SET_W + WAY_W;
   localparam int SIG_ENTRIES  = 1 << SIG_WIDTH;
   localparam int ROW_W        = NUM_WAYS * 2;

   localparam logic [PSEL_WIDTH-1:0] PSEL_MID = PSEL_WIDTH'(1 << (PSEL_WIDTH - 1));
   localparam logic [PSEL_WIDTH-1:0] PSEL_MAX = '1;
   localparam logic [15:0]           DECAY_RESET = 16'd4096;

   localparam logic [1:0] RRPV_DIST  = 2'd3;
   localparam logic [1:0] RRPV_LONG  = 2'd2;
   localparam logic [1:0] RRPV_NEAR  = 2'd0;
   localparam logic [1:0] DEAD_RESET = 2'd2;
   localparam logic [1:0] SCTR_RESET = 2'd1;

   typedef enum logic {
      ACT_VICTIM = 1'b0,
      ACT_UPDATE = 1'b1
   } action_type;

   typedef struct packed {
      logic       action;
      logic [10:0] set_index;
      logic [3:0] way;
      logic [7:0] pc_bits;
      logic       hit;
   } req_type;

   typedef struct packed {
      logic [3:0] victim_way;
      logic [1:0] insert_rrpv;
      logic       is_victim_reply;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_VREAD,
      ST_VAGE,
      ST_DECAY_RD,
      ST_DECAY_WR,
      ST_UREAD,
      ST_SIGRD,
      ST_UWRITE,
      ST_RESP
   } state_type;

   // Control from the sequencer to the storage.
   typedef struct packed {
      logic             clr_we;
      logic [SET_W-1:0] row_addr;
      logic             decay_we;
   } mem_ctl_type;

   // Saturating decrement of every nonzero 2-bit counter in a row.
   function automatic logic [ROW_W-1:0] decay_row(input logic [ROW_W-1:0] r);
      logic [ROW_W-1:0] o;
      for (int i = 0; i < NUM_WAYS; i++) begin
         o[2*i +: 2] = (r[2*i +: 2] != 2'd0) ? r[2*i +: 2] - 2'd1 : 2'd0;
      end
      return o;
   endfunction

endpackage

FILE: hdl/sdbrr_ager.sv
// ----------------------------------------------------------------------------
// sdbrr_ager
// Ages one set's RRPV row so that its largest entry becomes 3 and finds
// the lowest way holding 3.
// ----------------------------------------------------------------------------
module sdbrr_ager
   import sdbrr_pkg::*;
(
   input  logic [ROW_W-1:0] row_in,
   output logic [ROW_W-1:0] row_out,
   output logic [WAY_W-1:0] victim
);

   logic [1:0] top;

   always_comb begin
      top = 2'd0;
      for (int i = 0; i < NUM_WAYS; i++) begin
         if (row_in[2*i +: 2] > top) top = row_in[2*i +: 2];
      end
      for (int i = 0; i < NUM_WAYS; i++) begin
         row_out[2*i +: 2] = row_in[2*i +: 2] + (RRPV_DIST - top);
      end
      victim = '0;
      for (int i = NUM_WAYS - 1; i >= 0; i--) begin
         if (row_out[2*i +: 2] == RRPV_DIST) victim = WAY_W'(i);
      end
   end

endmodule

FILE: hdl/ship_dead_block_rrip_replacement_unit.sv
// ----------------------------------------------------------------------------
// ship_dead_block_rrip_replacement_unit
// Last-level cache replacement engine: RRIP with a signature predictor,
// per-block dead counters and set dueling.
// ----------------------------------------------------------------------------
// Usage: a request on req_* either asks for a victim way of a set or reports
// an access (hit or miss fill). Each request yields exactly one response on
// rsp_*. The csr_* channel writes decay_period and is taken at any time;
// the user must write it only while the block is idle, which is not enforced.
// Sequencing: a victim query reads the set's RRPV row, ages it and then
// responds; an update reads the rows, then the signature counters, writes
// back and responds. When the access count reaches the decay period, the
// update first decays the dead counters by a row sweep that reads and then
// writes each set in turn. A new request is taken only after the previous
// response is delivered; the memories have one port each.
// Reset: a clearing pass writes the reset values into every set, one row
// per cycle, during which req_ready is low.
// When rsp_ready is low the response holds in its register and no new
// request is taken until it is delivered.
// ----------------------------------------------------------------------------
module ship_dead_block_rrip_replacement_unit
   import sdbrr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  req_type     req_data,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output rsp_type     rsp_data,
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [15:0] csr_data
);

   // Row memories: one row per set, all ways side by side.
   logic [ROW_W-1:0]           rrpv_mem [NUM_SETS];
   logic [ROW_W-1:0]           dead_mem [NUM_SETS];
   logic [NUM_WAYS*SIG_WIDTH-1:0] sig_mem [NUM_SETS];
   logic [ROW_W-1:0]           rrpv_rd_ff, dead_rd_ff;
   logic [NUM_WAYS*SIG_WIDTH-1:0] sig_rd_ff;

   logic [1:0]            sctr_mem [SIG_ENTRIES];
   logic [1:0]            sctr_old_rd_ff, sctr_new_rd_ff, sctr_upd;
   logic [PSEL_WIDTH-1:0] psel_ff, psel_in;
   logic [15:0]           count_ff, count_in;
   logic [15:0]           period_ff;

   state_type state_ff, state_in;
   req_type   req_ff;
   rsp_type   rsp_ff, rsp_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic [SET_W-1:0] sweep_ff, sweep_in;
   mem_ctl_type ctl;

   logic [SET_W-1:0]     set_a;
   logic [WAY_W-1:0]     way_a;
   logic [SIG_WIDTH-1:0] new_sig, old_sig;
   logic [ROW_W-1:0]     aged_row;
   logic [WAY_W-1:0]     victim;
   logic [1:0]           old_dead, ins;
   logic                 lead_s, lead_b, brrip_mode;
   logic [16:0]          next_count, period_eff;
   logic                 decay_due;

   assign set_a = req_ff.set_index[SET_W-1:0];
   assign way_a = req_ff.way[WAY_W-1:0];
   assign new_sig = SIG_WIDTH'((req_ff.pc_bits >> 2) ^ 8'(req_ff.set_index[5:0]));
   assign old_sig = sig_rd_ff[way_a*SIG_WIDTH +: SIG_WIDTH];
   assign old_dead = dead_rd_ff[way_a*2 +: 2];

   assign csr_ready = 1'b1;
   assign req_ready = (state_ff == ST_IDLE) && !rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   sdbrr_ager u_ager (
      .row_in (rrpv_rd_ff),
      .row_out(aged_row),
      .victim (victim)
   );

   assign next_count = {1'b0, count_ff} + 17'd1;
   assign period_eff = (period_ff == 16'd0) ? 17'h10000 : {1'b0, period_ff};
   assign decay_due  = next_count >= period_eff;

   assign lead_s = {5'd0, set_a} < 16'(LEADER_SETS);
   assign lead_b = !lead_s && ({5'd0, set_a} < 16'(2 * LEADER_SETS));
   assign brrip_mode = lead_b || (!lead_s && (psel_ff < PSEL_MID));

   // Old signature's counter after the reward on a hit or the penalty on a miss.
   always_comb begin
      if (req_ff.hit) begin
         sctr_upd = (sctr_old_rd_ff < 2'd3) ? sctr_old_rd_ff + 2'd1 : 2'd3;
      end else begin
         sctr_upd = (sctr_old_rd_ff > 2'd0) ? sctr_old_rd_ff - 2'd1 : 2'd0;
      end
   end

   // Insertion decision; the new signature's counter is read together with the
   // old one, so the same-signature case uses the penalized value from sctr_upd.
   logic [1:0] sctr_eff;
   always_comb begin
      sctr_eff = (new_sig == old_sig) ? sctr_upd : sctr_new_rd_ff;
      if (req_ff.hit) begin
         ins = RRPV_NEAR;
      end else if (old_dead == 2'd0 && sctr_eff <= 2'd1) begin
         ins = RRPV_DIST;
      end else if (sctr_eff >= 2'd2 || old_dead >= 2'd2) begin
         ins = RRPV_NEAR;
      end else begin
         ins = brrip_mode ? RRPV_DIST : RRPV_LONG;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR:    if (sweep_ff == SET_W'(NUM_SETS - 1)) state_in = ST_IDLE;
         ST_IDLE: begin
            if (req_valid && req_ready) begin
               if (req_data.action == ACT_VICTIM) state_in = ST_VREAD;
               else if (decay_due) state_in = ST_DECAY_RD;
               else state_in = ST_UREAD;
            end
         end
         ST_VREAD:    state_in = ST_VAGE;
         ST_VAGE:     state_in = ST_RESP;
         ST_DECAY_RD: state_in = ST_DECAY_WR;
         ST_DECAY_WR: if (sweep_ff == SET_W'(NUM_SETS - 1)) state_in = ST_UREAD;
                      else state_in = ST_DECAY_RD;
         ST_UREAD:    state_in = ST_SIGRD;
         ST_SIGRD:    state_in = ST_UWRITE;
         ST_UWRITE:   state_in = ST_RESP;
         ST_RESP:     state_in = ST_IDLE;
         default:     state_in = ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      ctl = '0;
      sweep_in = sweep_ff;
      count_in = count_ff;
      psel_in = psel_ff;
      rsp_in = rsp_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      ctl.row_addr = set_a;
      case (state_ff)
         ST_CLEAR: begin
            ctl.clr_we = 1'b1;
            ctl.row_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_IDLE: begin
            sweep_in = '0;
            if (req_valid && req_ready && req_data.action == ACT_UPDATE) begin
               count_in = decay_due ? 16'd0 : next_count[15:0];
            end
         end
         ST_DECAY_RD: begin
            ctl.row_addr = sweep_ff;
         end
         ST_DECAY_WR: begin
            ctl.decay_we = 1'b1;
            ctl.row_addr = sweep_ff;
            sweep_in = sweep_ff + 1'b1;
         end
         ST_UWRITE: begin
            if (!req_ff.hit) begin
               if (old_dead == 2'd0 && sctr_eff <= 2'd1) begin
                  if (lead_b && psel_ff < PSEL_MAX) psel_in = psel_ff + 1'b1;
               end else if (sctr_eff >= 2'd2 || old_dead >= 2'd2) begin
                  if (lead_s && psel_ff > '0) psel_in = psel_ff - 1'b1;
               end
            end
            rsp_in.victim_way = 4'd0;
            rsp_in.insert_rrpv = ins;
            rsp_in.is_victim_reply = 1'b0;
         end
         ST_VAGE: begin
            rsp_in.victim_way = 4'(victim);
            rsp_in.insert_rrpv = 2'd0;
            rsp_in.is_victim_reply = 1'b1;
         end
         ST_RESP: rsp_valid_in = 1'b1;
         default: ;
      endcase
   end

   // Row memories: single address per cycle, registered reads.
   always_ff @(posedge clock) begin
      if (ctl.clr_we) begin
         rrpv_mem[ctl.row_addr] <= {NUM_WAYS{RRPV_LONG}};
         dead_mem[ctl.row_addr] <= {NUM_WAYS{DEAD_RESET}};
         sig_mem[ctl.row_addr]  <= '0;
      end else if (ctl.decay_we) begin
         dead_mem[ctl.row_addr] <= decay_row(dead_rd_ff);
      end else if (state_ff == ST_VAGE) begin
         rrpv_mem[ctl.row_addr] <= aged_row;
      end else if (state_ff == ST_UWRITE) begin
         logic [ROW_W-1:0] r;
         logic [ROW_W-1:0] d;
         logic [NUM_WAYS*SIG_WIDTH-1:0] s;
         r = rrpv_rd_ff;
         d = dead_rd_ff;
         s = sig_rd_ff;
         r[way_a*2 +: 2] = ins;
         if (req_ff.hit) begin
            d[way_a*2 +: 2] = (old_dead < 2'd3) ? old_dead + 2'd1 : 2'd3;
         end else begin
            d[way_a*2 +: 2] = DEAD_RESET;
            s[way_a*SIG_WIDTH +: SIG_WIDTH] = new_sig;
         end
         rrpv_mem[ctl.row_addr] <= r;
         dead_mem[ctl.row_addr] <= d;
         sig_mem[ctl.row_addr]  <= s;
      end
      rrpv_rd_ff <= rrpv_mem[ctl.row_addr];
      dead_rd_ff <= dead_mem[ctl.row_addr];
      sig_rd_ff  <= sig_mem[ctl.row_addr];
   end

   // Signature counters: cleared during the clearing pass, read at the old
   // and the new signature, and written back once per update.
   always_ff @(posedge clock) begin
      if (ctl.clr_we) begin
         sctr_mem[ctl.row_addr[SIG_WIDTH-1:0]] <= SCTR_RESET;
      end else if (state_ff == ST_UWRITE) begin
         sctr_mem[old_sig] <= sctr_upd;
      end
      sctr_old_rd_ff <= sctr_mem[old_sig];
      sctr_new_rd_ff <= sctr_mem[new_sig];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         sweep_ff     <= '0;
         count_ff     <= '0;
         psel_ff      <= PSEL_MID;
         period_ff    <= DECAY_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         sweep_ff     <= sweep_in;
         count_ff     <= count_in;
         psel_ff      <= psel_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_valid) period_ff <= csr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) req_ff <= req_data;
      rsp_ff      <= rsp_in;
   end

endmodule

FILE: tb/sv/ship_dead_block_rrip_replacement_unit_tb.sv
// ----------------------------------------------------------------------------
// ship_dead_block_rrip_replacement_unit_tb
// Self-checking bench for the dead-block RRIP replacement engine. A queue of
// victim queries and access updates feeds a clocked driver. An in-bench
// predictor tracks RRPV, signatures, dead counters and PSEL. A clocked
// monitor compares every response with the oldest prediction. The decay
// period is changed between phases, including its extremes.
// ----------------------------------------------------------------------------
module ship_dead_block_rrip_replacement_unit_tb;
   import sdbrr_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int TOTAL_BLOCKS = NUM_SETS * NUM_WAYS;
   localparam int STALL_LIMIT  = 20000;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   req_type     req_data;
   logic        rsp_valid;
   logic        rsp_ready;
   rsp_type     rsp_data;
   logic        csr_valid;
   logic        csr_ready;
   logic [15:0] csr_data;

   ship_dead_block_rrip_replacement_unit u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   // Shadow copy of the replacement state.
   bit [1:0]            rrpv_shadow  [TOTAL_BLOCKS];
   bit [SIG_WIDTH-1:0]  sig_shadow   [TOTAL_BLOCKS];
   bit [1:0]            dead_shadow  [TOTAL_BLOCKS];
   bit [1:0]            sctr_shadow  [SIG_ENTRIES];
   bit [PSEL_WIDTH-1:0] psel_shadow;
   int unsigned         access_shadow;
   int unsigned         period_shadow;

   req_type     pending_req_q [$];
   rsp_type     expected_rsp_q [$];
   int          error_count;
   int          victim_count, hit_count, miss_count, decay_count;
   int          req_gap, rsp_gap, stall_cycles;
   bit          quiet;
   int          hot_sets [12];

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic rsp_type predict_replacement(req_type r);
      rsp_type     o;
      int unsigned set, way, base, top, idx, sig, old_sig, old_dead, sctr, period;
      bit          lead_s, lead_b, brrip_mode;
      bit [1:0]    ins;
      o = '0;
      set = r.set_index % NUM_SETS;
      way = r.way % NUM_WAYS;
      base = set * NUM_WAYS;
      if (r.action == ACT_VICTIM) begin
         top = 0;
         for (int w = 0; w < NUM_WAYS; w++)
            if (rrpv_shadow[base + w] > top) top = rrpv_shadow[base + w];
         if (top < 3)
            for (int w = 0; w < NUM_WAYS; w++)
               rrpv_shadow[base + w] = rrpv_shadow[base + w] + 2'(3 - top);
         for (int w = NUM_WAYS - 1; w >= 0; w--)
            if (rrpv_shadow[base + w] == 2'd3) o.victim_way = 4'(w);
         o.is_victim_reply = 1'b1;
         victim_count++;
         return o;
      end
      period = (period_shadow == 0) ? 65536 : period_shadow;
      if (access_shadow + 1 >= period) begin
         access_shadow = 0;
         decay_count++;
         for (int i = 0; i < TOTAL_BLOCKS; i++)
            if (dead_shadow[i] != 0) dead_shadow[i]--;
      end else begin
         access_shadow = (access_shadow + 1) & 16'hFFFF;
      end
      idx = base + way;
      sig = ((r.pc_bits >> 2) ^ (set & 6'h3F)) & (SIG_ENTRIES - 1);
      old_sig = sig_shadow[idx];
      if (r.hit) begin
         hit_count++;
         if (sctr_shadow[old_sig] < 3) sctr_shadow[old_sig]++;
         if (dead_shadow[idx] < 3) dead_shadow[idx]++;
         ins = RRPV_NEAR;
      end else begin
         miss_count++;
         if (sctr_shadow[old_sig] > 0) sctr_shadow[old_sig]--;
         sig_shadow[idx] = SIG_WIDTH'(sig);
         old_dead = dead_shadow[idx];
         dead_shadow[idx] = DEAD_RESET;
         lead_s = set < LEADER_SETS;
         lead_b = !lead_s && set < 2 * LEADER_SETS;
         brrip_mode = lead_s ? 1'b0 : (lead_b ? 1'b1 : (psel_shadow < PSEL_MID));
         sctr = sctr_shadow[sig];
         if (old_dead == 0 && sctr <= 1) begin
            ins = RRPV_DIST;
            if (lead_b && psel_shadow < PSEL_MAX) psel_shadow++;
         end else if (sctr >= 2 || old_dead >= 2) begin
            ins = RRPV_NEAR;
            if (lead_s && psel_shadow > 0) psel_shadow--;
         end else begin
            ins = brrip_mode ? RRPV_DIST : RRPV_LONG;
         end
      end
      rrpv_shadow[idx] = ins;
      o.insert_rrpv = ins;
      return o;
   endfunction

   function automatic req_type make_req(action_type a, int set, int way, int pc, bit hit);
      req_type r;
      r.action = a;
      r.set_index = 11'(set);
      r.way = 4'(way);
      r.pc_bits = 8'(pc);
      r.hit = hit;
      return r;
   endfunction

   // Mostly a small pool of sets so that fills, hits and queries interact.
   function automatic req_type random_req();
      int set;
      set = ($urandom_range(0, 9) < 8) ? hot_sets[$urandom_range(0, 11)]
                                       : $urandom_range(0, NUM_SETS - 1);
      return make_req(($urandom_range(0, 2) == 0) ? ACT_VICTIM : ACT_UPDATE, set,
                      $urandom_range(0, 15), $urandom_range(0, 255),
                      $urandom_range(0, 1));
   endfunction

   // Request driver; the predictor runs on each accepted request.
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   <= 0;
      end else begin
         if (req_valid && req_ready)
            expected_rsp_q.push_back(predict_replacement(req_data));
         if (!req_valid || req_ready) begin
            if (req_gap > 0) begin
               req_gap   <= req_gap - 1;
               req_valid <= 1'b0;
            end else if (pending_req_q.size() != 0) begin
               req_data  <= pending_req_q.pop_front();
               req_valid <= 1'b1;
               if (!quiet && $urandom_range(0, 4) == 0) req_gap <= $urandom_range(1, 4);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // Response monitor with random back-pressure.
   always @(posedge clock) begin
      rsp_type exp_rsp;
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_rsp_q.size() == 0) begin
               $display("%0t: unexpected response, actual %p", $time, rsp_data);
               error_count++;
            end else begin
               exp_rsp = expected_rsp_q.pop_front();
               if (rsp_data.victim_way !== exp_rsp.victim_way) begin
                  $display("%0t: victim_way expected %0d actual %0d", $time,
                           exp_rsp.victim_way, rsp_data.victim_way);
                  error_count++;
               end
               if (rsp_data.insert_rrpv !== exp_rsp.insert_rrpv) begin
                  $display("%0t: insert_rrpv expected %0d actual %0d", $time,
                           exp_rsp.insert_rrpv, rsp_data.insert_rrpv);
                  error_count++;
               end
               if (rsp_data.is_victim_reply !== exp_rsp.is_victim_reply) begin
                  $display("%0t: is_victim_reply expected %0d actual %0d", $time,
                           exp_rsp.is_victim_reply, rsp_data.is_victim_reply);
                  error_count++;
               end
            end
         end
         if (rsp_gap > 0) begin
            rsp_gap   <= rsp_gap - 1;
            rsp_ready <= 1'b0;
         end else if (!quiet && $urandom_range(0, 5) == 0) begin
            rsp_gap   <= $urandom_range(0, 3);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   // Watchdog on cycles in which no handshake completes.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)
          || (csr_valid && csr_ready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("ship_dead_block_rrip_replacement_unit regression: fail");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   task automatic drain_requests();
      while (pending_req_q.size() != 0 || req_valid || expected_rsp_q.size() != 0)
         @(posedge clock);
      repeat (12) @(posedge clock);
   endtask

   task automatic write_decay_period(logic [15:0] value);
      drain_requests();
      csr_valid <= 1'b1;
      csr_data  <= value;
      do @(posedge clock); while (!(csr_valid && csr_ready));
      period_shadow = value;
      csr_valid <= 1'b0;
   endtask

   task automatic queue_random(int count);
      for (int i = 0; i < count; i++) pending_req_q.push_back(random_req());
   endtask

   initial begin
      int dir_sets [8];
      dir_sets = '{0, 31, 32, 63, 64, 1000, 1365, 2047};
      reset = 1'b1;
      csr_valid = 1'b0;
      csr_data = '0;
      req_valid = 1'b0;
      req_data = '0;
      rsp_ready = 1'b0;
      quiet = 1'b0;
      error_count = 0;
      stall_cycles = 0;
      for (int i = 0; i < TOTAL_BLOCKS; i++) begin
         rrpv_shadow[i] = 2'd2;
         sig_shadow[i]  = '0;
         dead_shadow[i] = DEAD_RESET;
      end
      for (int i = 0; i < SIG_ENTRIES; i++) sctr_shadow[i] = SCTR_RESET;
      psel_shadow = PSEL_MID;
      access_shadow = 0;
      period_shadow = DECAY_RESET;
      for (int i = 0; i < 12; i++)
         hot_sets[i] = (i < 4) ? $urandom_range(0, 31)
                     : (i < 8) ? $urandom_range(32, 63) : $urandom_range(64, 2047);
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Directed: leader and follower sets, field extremes, hit and miss.
      foreach (dir_sets[i]) begin
         pending_req_q.push_back(make_req(ACT_VICTIM, dir_sets[i], 0, 0, 1'b0));
         pending_req_q.push_back(make_req(ACT_UPDATE, dir_sets[i], (i % 2) ? 15 : 0,
                                          (i % 2) ? 255 : 0, 1'b0));
      end
      pending_req_q.push_back(make_req(ACT_UPDATE, 2047, 15, 255, 1'b1));
      pending_req_q.push_back(make_req(ACT_UPDATE, 0, 0, 0, 1'b1));
      pending_req_q.push_back(make_req(ACT_VICTIM, 2047, 15, 255, 1'b1));
      pending_req_q.push_back(make_req(ACT_VICTIM, 0, 0, 0, 1'b0));
      queue_random(280);

      write_decay_period(16'hFFFF);
      queue_random(180);
      write_decay_period(16'd0);
      queue_random(100);
      // A period of one decays on every update, which costs a full sweep each.
      write_decay_period(16'd1);
      for (int i = 0; i < 6; i++) begin
         pending_req_q.push_back(make_req(ACT_UPDATE, hot_sets[i], $urandom_range(0, 15),
                                          $urandom_range(0, 255), $urandom_range(0, 1)));
         pending_req_q.push_back(make_req(ACT_VICTIM, hot_sets[i], 0, 0, 1'b0));
      end
      write_decay_period(16'd37);
      queue_random(120);
      while (pending_req_q.size() != 0) @(posedge clock);
      quiet = 1'b1;
      queue_random(100);
      drain_requests();

      $display("Covered %0d victim queries, %0d hits, %0d miss fills, %0d decay sweeps;",
               victim_count, hit_count, miss_count, decay_count);
      $display("decay period swept over 4096, 65535, 0, 1 and 37; final PSEL %0d.",
               psel_shadow);
      if (error_count == 0) begin
         $display("ship_dead_block_rrip_replacement_unit regression: pass");
      end else begin
         $display("ship_dead_block_rrip_replacement_unit regression: fail");
      end
      $finish;
   end

endmodule

FILE: filelist.f
hdl/sdbrr_pkg.sv
hdl/sdbrr_ager.sv
hdl/ship_dead_block_rrip_replacement_unit.sv
tb/sv/ship_dead_block_rrip_replacement_unit_tb.sv
